// ----- sv/ps2_command_queue_link_assert.svh -----
// Assertion macros for the keyboard command queue link
`ifndef PS2_COMMAND_QUEUE_LINK_ASSERT_SVH
`define PS2_COMMAND_QUEUE_LINK_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PS2Q_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ps2q invariant failed");
`define PS2Q_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2q next-cycle check failed");
`else
`define PS2Q_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PS2Q_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/ps2q_pkg.sv -----
// Types, constants and helpers for the keyboard command queue link
package ps2q_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic       OP_ENQUEUE = 1'b0;
    localparam logic       OP_RECEIVE = 1'b1;

    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_RESEND = 8'hFE;
    localparam logic [7:0] BYTE_RESET  = 8'hFF;
    localparam logic [7:0] BYTE_PASS   = 8'hAA;
    localparam logic [7:0] BYTE_ECHO   = 8'hEE;
    localparam logic [7:0] BYTE_FAIL0  = 8'hFC;
    localparam logic [7:0] BYTE_FAIL1  = 8'hFD;
    localparam logic [7:0] BYTE_ERR0   = 8'h00;
    localparam logic [7:0] BYTE_ERR1   = 8'hFF;

    localparam logic [3:0] MAX_RESENDS_RST = 4'd3;

    typedef enum logic [1:0] {
        LINK_IDLE      = 2'd0,
        LINK_WAIT_ACK  = 2'd1,
        LINK_WAIT_RESP = 2'd2
    } t_link;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_ACKED   = 4'd1,
        EV_DROPPED = 4'd2,
        EV_PASS    = 4'd3,
        EV_ECHO    = 4'd4,
        EV_FAIL    = 4'd5,
        EV_ERROR   = 4'd6,
        EV_OTHER   = 4'd7,
        EV_SCAN    = 4'd8,
        EV_FULL    = 4'd9
    } t_event;

    function automatic t_event classify(input logic [7:0] b);
        t_event ev;
        case (b)
            BYTE_PASS:              ev = EV_PASS;
            BYTE_ECHO:              ev = EV_ECHO;
            BYTE_FAIL0, BYTE_FAIL1: ev = EV_FAIL;
            BYTE_ERR0, BYTE_ERR1:   ev = EV_ERROR;
            default:                ev = EV_OTHER;
        endcase
        return ev;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- sv/ps2_command_queue_link.sv -----
// Top level: host-side keyboard command queue and reply handling
// Commands wait in a small queue; the head byte goes out whenever the link is
// idle, then the block waits for an ack (0xFA) or resend (0xFE); after an acked
// reset (0xFF) the next byte is reported as the self-test outcome, and bytes
// arriving while idle come out as scan bytes. Every input beat yields exactly
// one result beat. One beat per cycle is sustained unless i_ready stalls; a beat
// crosses an input register, a queue/link update pass and a result register.
// The head command byte is held in a register and the entry behind it is
// prefetched from the queue memory every cycle, so a pop never waits on a read.
// Users must write max_resends via its own channel only while idle (not enforced).
`include "ps2_command_queue_link_assert.svh"

module ps2_command_queue_link (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_send_valid,
    output logic [7:0] o_send_byte,
    output logic [3:0] o_event_res,
    output logic [7:0] o_forwarded_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_max_resends
);

    localparam int PW = ps2q_pkg::PTR_W;
    localparam int CW = ps2q_pkg::CNT_W;

    // config
    logic [3:0] r_max_resends;

    // input stage
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // link/queue state
    ps2q_pkg::t_link r_link, n_link;
    logic [3:0]      r_resend, n_resend;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_head, n_head;
    logic [7:0]      r_head_byte, n_head_byte;
    logic [7:0]      r_second;
    logic [7:0]      r_mem [ps2q_pkg::QUEUE_DEPTH];

    // result stage
    logic                r_out_valid;
    logic                r_out_send;
    logic [7:0]          r_out_send_byte;
    ps2q_pkg::t_event    r_out_event;
    logic [7:0]          r_out_fwd;

    logic                fire;
    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    logic [PW-1:0]       rd_addr;
    logic [CW:0]         wr_sum;
    logic                pop;
    ps2q_pkg::t_link     link_mid;
    logic [CW-1:0]       count_mid;
    logic                send;
    logic [7:0]          send_byte;
    ps2q_pkg::t_event    ev;
    logic [7:0]          fwd;

    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    // tail address = head + count, wrapped
    always_comb begin
        wr_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
        if (wr_sum >= (CW+1)'(ps2q_pkg::QUEUE_DEPTH)) begin
            wr_sum = wr_sum - (CW+1)'(ps2q_pkg::QUEUE_DEPTH);
        end
        wr_addr = wr_sum[PW-1:0];
    end

    // one pass of the link protocol
    always_comb begin
        link_mid    = r_link;
        n_resend    = r_resend;
        count_mid   = r_count;
        n_head      = r_head;
        n_head_byte = r_head_byte;
        ev          = ps2q_pkg::EV_NONE;
        fwd         = 8'd0;
        pop         = 1'b0;
        wr_en       = 1'b0;
        if (r_in_op == ps2q_pkg::OP_ENQUEUE) begin
            if (r_count == CW'(ps2q_pkg::QUEUE_DEPTH)) begin
                ev = ps2q_pkg::EV_FULL;
            end else begin
                wr_en     = fire;
                count_mid = r_count + CW'(1);
                if (r_count == '0) begin
                    n_head_byte = r_in_byte;
                end
            end
        end else begin
            case (r_link)
                ps2q_pkg::LINK_WAIT_ACK: begin
                    if (r_in_byte == ps2q_pkg::BYTE_ACK) begin
                        pop      = 1'b1;
                        n_resend = 4'd0;
                        ev       = ps2q_pkg::EV_ACKED;
                        if (r_count != '0 && r_head_byte == ps2q_pkg::BYTE_RESET) begin
                            link_mid = ps2q_pkg::LINK_WAIT_RESP;
                        end else begin
                            link_mid = ps2q_pkg::LINK_IDLE;
                        end
                    end else if (r_in_byte == ps2q_pkg::BYTE_RESEND) begin
                        if (r_resend >= r_max_resends) begin
                            pop      = 1'b1;
                            n_resend = 4'd0;
                            ev       = ps2q_pkg::EV_DROPPED;
                        end else begin
                            n_resend = r_resend + 4'd1;
                        end
                        link_mid = ps2q_pkg::LINK_IDLE;
                    end else begin
                        ev = ps2q_pkg::EV_OTHER;
                    end
                end
                ps2q_pkg::LINK_WAIT_RESP: begin
                    ev       = ps2q_pkg::classify(r_in_byte);
                    link_mid = ps2q_pkg::LINK_IDLE;
                end
                default: begin
                    // idle, and the unused code, forward as scan data
                    link_mid = ps2q_pkg::LINK_IDLE;
                    ev       = ps2q_pkg::EV_SCAN;
                    fwd      = r_in_byte;
                end
            endcase
        end
        if (pop && r_count != '0) begin
            n_head      = ps2q_pkg::ptr_inc(r_head);
            count_mid   = r_count - CW'(1);
            n_head_byte = r_second;
        end
        n_count = count_mid;
        // idle link with a queued command sends the head right away
        send      = (link_mid == ps2q_pkg::LINK_IDLE) && (count_mid != '0);
        send_byte = send ? n_head_byte : 8'd0;
        n_link    = send ? ps2q_pkg::LINK_WAIT_ACK : link_mid;
    end

    assign rd_addr = ps2q_pkg::ptr_inc(fire ? n_head : r_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_resends <= ps2q_pkg::MAX_RESENDS_RST;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_link        <= ps2q_pkg::LINK_IDLE;
            r_resend      <= 4'd0;
            r_count       <= '0;
            r_head        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_resends <= i_cfg_max_resends;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_link      <= n_link;
                r_resend    <= n_resend;
                r_count     <= n_count;
                r_head      <= n_head;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op   <= i_opcode;
            r_in_byte <= i_data_byte;
        end
        if (fire) begin
            r_head_byte     <= n_head_byte;
            r_out_send      <= send;
            r_out_send_byte <= send_byte;
            r_out_event     <= ev;
            r_out_fwd       <= fwd;
        end
    end

    // queue memory: one write port, one registered read of the entry behind head
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == rd_addr) begin
            r_second <= r_in_byte;
        end else begin
            r_second <= r_mem[rd_addr];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_send_valid     = r_out_send;
    assign o_send_byte      = r_out_send_byte;
    assign o_event_res      = r_out_event;
    assign o_forwarded_byte = r_out_fwd;

    `PS2Q_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(ps2q_pkg::QUEUE_DEPTH))
    `PS2Q_ASSERT_NEXT(a_send_waits_ack, i_clk, i_rst_n, fire && send, r_link == ps2q_pkg::LINK_WAIT_ACK && r_count != '0)
    `PS2Q_ASSERT_NEXT(a_first_enq_head, i_clk, i_rst_n, fire && r_in_op == ps2q_pkg::OP_ENQUEUE && r_count == '0, r_head_byte == $past(r_in_byte))

endmodule

// ----- test/ps2_command_queue_link_checker.sv -----
// Checker for the keyboard command queue link: predicts each result beat and compares
`timescale 1ns / 100ps

module ps2_command_queue_link_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_send_valid,
    input  logic [7:0] i_send_byte,
    input  logic [3:0] i_event_res,
    input  logic [7:0] i_forwarded_byte,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [3:0] i_cfg_max_resends,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic              send_valid;
        logic [7:0]        send_byte;
        ps2q_pkg::t_event  event_res;
        logic [7:0]        forwarded_byte;
    } t_link_result;

    ps2q_pkg::t_link            link_state;
    logic [3:0]                 resend_count;
    logic [3:0]                 resend_limit;
    logic [7:0]                 cmd_queue [ps2q_pkg::QUEUE_DEPTH];
    logic [ps2q_pkg::PTR_W-1:0] cmd_head;
    logic [ps2q_pkg::CNT_W-1:0] cmd_count;
    t_link_result               pending_results [$];
    int                         fail_count    = 0;
    int                         pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void drop_head_cmd();
        if (cmd_count != '0) begin
            cmd_head  = (cmd_head == ps2q_pkg::PTR_W'(ps2q_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : cmd_head + 1'b1;
            cmd_count = cmd_count - 1'b1;
        end
    endfunction

    function automatic t_link_result advance_link(input logic op, input logic [7:0] b);
        t_link_result r;
        logic         head_is_reset;
        logic         offer;
        r             = '0;
        r.event_res   = ps2q_pkg::EV_NONE;
        offer         = 1'b1;
        head_is_reset = 1'b0;
        if (op == ps2q_pkg::OP_ENQUEUE) begin
            if (int'(cmd_count) >= ps2q_pkg::QUEUE_DEPTH) begin
                r.event_res = ps2q_pkg::EV_FULL;
                offer       = 1'b0;
            end else begin
                cmd_queue[(int'(cmd_head) + int'(cmd_count)) % ps2q_pkg::QUEUE_DEPTH] = b;
                cmd_count = cmd_count + 1'b1;
            end
        end else begin
            case (link_state)
                ps2q_pkg::LINK_WAIT_ACK: begin
                    if (b == ps2q_pkg::BYTE_ACK) begin
                        if (cmd_count != '0) begin
                            head_is_reset = (cmd_queue[cmd_head] == ps2q_pkg::BYTE_RESET);
                        end
                        drop_head_cmd();
                        resend_count = '0;
                        r.event_res  = ps2q_pkg::EV_ACKED;
                        link_state   = head_is_reset ? ps2q_pkg::LINK_WAIT_RESP
                                                     : ps2q_pkg::LINK_IDLE;
                    end else if (b == ps2q_pkg::BYTE_RESEND) begin
                        if (resend_count >= resend_limit) begin
                            drop_head_cmd();
                            resend_count = '0;
                            r.event_res  = ps2q_pkg::EV_DROPPED;
                        end else begin
                            resend_count = resend_count + 1'b1;
                        end
                        link_state = ps2q_pkg::LINK_IDLE;
                    end else begin
                        r.event_res = ps2q_pkg::EV_OTHER;
                        offer       = 1'b0;
                    end
                end
                ps2q_pkg::LINK_WAIT_RESP: begin
                    case (b)
                        ps2q_pkg::BYTE_PASS: r.event_res = ps2q_pkg::EV_PASS;
                        ps2q_pkg::BYTE_ECHO: r.event_res = ps2q_pkg::EV_ECHO;
                        ps2q_pkg::BYTE_FAIL0, ps2q_pkg::BYTE_FAIL1:
                            r.event_res = ps2q_pkg::EV_FAIL;
                        ps2q_pkg::BYTE_ERR0, ps2q_pkg::BYTE_ERR1:
                            r.event_res = ps2q_pkg::EV_ERROR;
                        default: r.event_res = ps2q_pkg::EV_OTHER;
                    endcase
                    link_state = ps2q_pkg::LINK_IDLE;
                end
                default: begin
                    r.event_res      = ps2q_pkg::EV_SCAN;
                    r.forwarded_byte = b;
                    offer            = 1'b0;
                end
            endcase
        end
        // head goes out as soon as the link is free
        if (offer && link_state == ps2q_pkg::LINK_IDLE && cmd_count != '0) begin
            r.send_valid = 1'b1;
            r.send_byte  = cmd_queue[cmd_head];
            link_state   = ps2q_pkg::LINK_WAIT_ACK;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_link_result want;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            link_state   = ps2q_pkg::LINK_IDLE;
            resend_count = '0;
            resend_limit = ps2q_pkg::MAX_RESENDS_RST;
            cmd_head     = '0;
            cmd_count    = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                resend_limit = i_cfg_max_resends;
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing pending: event_res=%0d", i_event_res);
                    errs++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_send_valid !== want.send_valid) begin
                        $error("send_valid: expected %0d, got %0d",
                               want.send_valid, i_send_valid);
                        errs++;
                    end
                    if (i_send_byte !== want.send_byte) begin
                        $error("send_byte: expected 0x%02h, got 0x%02h",
                               want.send_byte, i_send_byte);
                        errs++;
                    end
                    if (i_event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, i_event_res);
                        errs++;
                    end
                    if (i_forwarded_byte !== want.forwarded_byte) begin
                        $error("forwarded_byte: expected 0x%02h, got 0x%02h",
                               want.forwarded_byte, i_forwarded_byte);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(advance_link(i_opcode, i_data_byte));
            end
        end
        pending_count <= pending_results.size();
        fail_count    <= fail_count + errs;
    end

endmodule

// ----- test/ps2_command_queue_link_tb.sv -----
// Testbench top for the keyboard command queue link: stimulus, flow control and verdict
`timescale 1ns / 100ps

module ps2_command_queue_link_tb;

    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_opcode;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_ready;
    logic       o_send_valid;
    logic [7:0] o_send_byte;
    logic [3:0] o_event_res;
    logic [7:0] o_forwarded_byte;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_max_resends;

    int         fail_count;
    int         pending;
    int         beats_sent   = 0;
    int         burst_left   = 1;
    logic [3:0] resend_limit = ps2q_pkg::MAX_RESENDS_RST;
    bit         hold_off_req = 1'b0;

    always #5 i_clk = ~i_clk;

    ps2_command_queue_link dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_data_byte       (i_data_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_send_valid      (o_send_valid),
        .o_send_byte       (o_send_byte),
        .o_event_res       (o_event_res),
        .o_forwarded_byte  (o_forwarded_byte),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_max_resends (i_cfg_max_resends)
    );

    ps2_command_queue_link_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_opcode          (i_opcode),
        .i_data_byte       (i_data_byte),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_send_valid      (o_send_valid),
        .i_send_byte       (o_send_byte),
        .i_event_res       (o_event_res),
        .i_forwarded_byte  (o_forwarded_byte),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_max_resends (i_cfg_max_resends),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // receiver: random stall density per segment, plus one long hold-off on request
    initial begin : result_sink
        int stall_pct;
        int seg_left;
        stall_pct = 0;
        seg_left  = 0;
        i_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 96);
                    case ($urandom_range(3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] b);
        int gap;
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(19) == 0) gap = 25;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(9) == 0) ? 120 : $urandom_range(1, 24);
        end
    endtask

    // wait until every predicted result has come out, then let the pipe empty
    task automatic settle_link();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_resends(input logic [3:0] v);
        i_cfg_valid       <= 1'b1;
        i_cfg_max_resends <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        resend_limit  = v;
    endtask

    function automatic logic [7:0] random_command();
        return ($urandom_range(4) == 0) ? ps2q_pkg::BYTE_RESET : 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] self_test_byte();
        logic [7:0] b;
        case ($urandom_range(6))
            0:       b = ps2q_pkg::BYTE_PASS;
            1:       b = ps2q_pkg::BYTE_ECHO;
            2:       b = ps2q_pkg::BYTE_FAIL0;
            3:       b = ps2q_pkg::BYTE_FAIL1;
            4:       b = ps2q_pkg::BYTE_ERR0;
            5:       b = ps2q_pkg::BYTE_ERR1;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    task automatic random_exchange();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 25) begin
            send_beat(ps2q_pkg::OP_ENQUEUE, random_command());
        end else if (pick < 45) begin
            send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_ACK);
        end else if (pick < 60) begin
            // resend run, sometimes long enough to hit the limit
            n = $urandom_range(0, int'(resend_limit) + 1);
            repeat (n) send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_RESEND);
            send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_ACK);
        end else if (pick < 75) begin
            send_beat(ps2q_pkg::OP_ENQUEUE, ps2q_pkg::BYTE_RESET);
            send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_ACK);
            send_beat(ps2q_pkg::OP_RECEIVE, self_test_byte());
        end else if (pick < 82) begin
            send_beat(ps2q_pkg::OP_RECEIVE, self_test_byte());
        end else if (pick < 85) begin
            repeat ($urandom_range(6, 10)) send_beat(ps2q_pkg::OP_ENQUEUE, random_command());
        end else begin
            send_beat(ps2q_pkg::OP_RECEIVE, 8'($urandom_range(255)));
        end
    endtask

    initial begin : timeout
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_opcode          = ps2q_pkg::OP_ENQUEUE;
        i_data_byte       = 8'h00;
        i_cfg_valid       = 1'b0;
        i_cfg_max_resends = 4'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle link: received bytes pass through as scan bytes
        send_beat(ps2q_pkg::OP_RECEIVE, 8'h00);
        send_beat(ps2q_pkg::OP_RECEIVE, 8'hFF);
        // acked reset with a stray byte and a resend before the ack
        send_beat(ps2q_pkg::OP_ENQUEUE, ps2q_pkg::BYTE_RESET);
        send_beat(ps2q_pkg::OP_RECEIVE, 8'h55);
        send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_RESEND);
        send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_ACK);
        send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_PASS);
        send_beat(ps2q_pkg::OP_ENQUEUE, ps2q_pkg::BYTE_RESET);
        send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_ACK);
        send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_FAIL1);
        // resends past the default limit drop the command
        send_beat(ps2q_pkg::OP_ENQUEUE, 8'h00);
        repeat (4) send_beat(ps2q_pkg::OP_RECEIVE, ps2q_pkg::BYTE_RESEND);
        // fill the queue, the last enqueue overflows
        send_beat(ps2q_pkg::OP_ENQUEUE, 8'hED);
        repeat (7) send_beat(ps2q_pkg::OP_ENQUEUE, 8'($urandom_range(255)));
        send_beat(ps2q_pkg::OP_ENQUEUE, 8'hF4);
        settle_link();

        write_max_resends(4'd0);
        // long receiver hold-off while the sender keeps offering beats
        burst_left   = 64;
        hold_off_req = 1'b1;
        repeat (30) random_exchange();
        while (beats_sent < 650) random_exchange();
        settle_link();

        write_max_resends(4'd15);
        while (beats_sent < 1200) random_exchange();
        settle_link();

        write_max_resends(4'($urandom_range(1, 14)));
        while (beats_sent < 1800) random_exchange();
        settle_link();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ps2q_pkg.sv
sv/ps2_command_queue_link.sv
test/ps2_command_queue_link_checker.sv
test/ps2_command_queue_link_tb.sv
